@@ hdl/ranked_ballot_tally_unit_macros.svh @@
// Assertion macros shared by the tally unit RTL.
`ifndef RANKED_BALLOT_TALLY_UNIT_MACROS_SVH
`define RANKED_BALLOT_TALLY_UNIT_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, clocked on clk, off during reset.
`define RBT_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define RBT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define RBT_ASSERT_SAME(lbl, ante, cons, msg)
`define RBT_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

@@ hdl/rbt_pkg.sv @@
// Types and constants shared by the ranked ballot tally RTL.
`timescale 1ns / 1ps
package rbt_pkg;

	localparam int MAX_CANDIDATES_DEF = 8;
	localparam int COUNT_WIDTH_DEF = 16;

	localparam int ID_W = 3;
	localparam int ID_SPAN = 8;
	localparam int CFG_W = 4;
	localparam int POS_W = 3;
	localparam int SCORE_W = 20;

	localparam logic [CFG_W-1:0] CFG_RESET = 4'd3;
	localparam logic [CFG_W-1:0] CFG_MIN = 4'd2;
	localparam logic [POS_W-1:0] POS_LAST = 3'd7;

	typedef enum logic [1:0] {
		S_IDLE,
		S_WALK,
		S_EMIT
	} state_t;

	// Broadcast from the top to every cell for one accepted word.
	typedef struct packed {
		logic               hit;
		logic [ID_W-1:0]    id;
		logic [POS_W-1:0]   pts;
		logic               close;
		logic [ID_SPAN-1:0] old_seen;
		logic [ID_SPAN-1:0] new_seen;
		logic [ID_SPAN-1:0] active;
	} entry_t;

	// Running winners handed from cell to cell.
	typedef struct packed {
		logic [SCORE_W-1:0] best_score;
		logic [ID_W-1:0]    best_idx;
		logic               found;
		logic [ID_W-1:0]    cond_idx;
	} token_t;

	typedef struct packed {
		logic busy;
		logic load;
		logic last;
		logic clear;
	} seq_ctl_t;

endpackage

@@ hdl/rbt_cell.sv @@
// One candidate cell: Borda score, its pairwise row and column, winner token stage.
`timescale 1ns / 1ps
module rbt_cell #(
	parameter int CELLS = rbt_pkg::MAX_CANDIDATES_DEF,
	parameter int COUNT_WIDTH = rbt_pkg::COUNT_WIDTH_DEF,
	parameter int CELL_INDEX = 0
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  rbt_pkg::entry_t              entry,
	input  logic                         clear,
	input  rbt_pkg::token_t              tok_in,
	output rbt_pkg::token_t              tok_out,
	output logic [rbt_pkg::SCORE_W-1:0]  score
);
	import rbt_pkg::*;

	localparam logic [ID_W-1:0] MY_ID = ID_W'(CELL_INDEX);

	// row_q[o]: times this candidate ranked above o; col_q[o]: times o ranked above it
	logic [COUNT_WIDTH-1:0] row_q [CELLS];
	logic [COUNT_WIDTH-1:0] col_q [CELLS];
	logic [CELLS-1:0]       row_inc;
	logic [CELLS-1:0]       col_inc;
	logic [SCORE_W-1:0]     score_q;
	logic [SCORE_W:0]       score_sum;
	logic                   score_hit;
	logic                   beats;
	token_t                 tok_next;
	token_t                 token_q;

	always_comb begin
		for (int o = 0; o < CELLS; o++) begin
			row_inc[o] = entry.active[CELL_INDEX] && entry.active[o] &&
				((entry.hit && entry.old_seen[CELL_INDEX] && entry.id == ID_W'(o)) ||
				 (entry.close && entry.new_seen[CELL_INDEX] && !entry.new_seen[o]));
			col_inc[o] = entry.active[CELL_INDEX] && entry.active[o] &&
				((entry.hit && entry.old_seen[o] && entry.id == MY_ID) ||
				 (entry.close && entry.new_seen[o] && !entry.new_seen[CELL_INDEX]));
		end
	end

	assign score_hit = entry.hit && entry.id == MY_ID;
	assign score_sum = {1'b0, score_q} + (SCORE_W+1)'(entry.pts);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			score_q <= '0;
			for (int o = 0; o < CELLS; o++) begin
				row_q[o] <= '0;
				col_q[o] <= '0;
			end
		end else if (clear) begin
			score_q <= '0;
			for (int o = 0; o < CELLS; o++) begin
				row_q[o] <= '0;
				col_q[o] <= '0;
			end
		end else begin
			if (score_hit) begin
				score_q <= score_sum[SCORE_W] ? '1 : score_sum[SCORE_W-1:0];
			end
			// saturate: hold at all ones
			for (int o = 0; o < CELLS; o++) begin
				if (row_inc[o] && row_q[o] != '1) begin
					row_q[o] <= row_q[o] + COUNT_WIDTH'(1);
				end
				if (col_inc[o] && col_q[o] != '1) begin
					col_q[o] <= col_q[o] + COUNT_WIDTH'(1);
				end
			end
		end
	end

	// strictly ahead of every other candidate in use
	always_comb begin
		beats = 1'b1;
		for (int o = 0; o < CELLS; o++) begin
			if (o != CELL_INDEX && entry.active[o] && !(row_q[o] > col_q[o])) begin
				beats = 1'b0;
			end
		end
	end

	always_comb begin
		tok_next = tok_in;
		if (entry.active[CELL_INDEX]) begin
			if (score_q > tok_in.best_score) begin
				tok_next.best_score = score_q;
				tok_next.best_idx = MY_ID;
			end
			if (!tok_in.found && beats) begin
				tok_next.found = 1'b1;
				tok_next.cond_idx = MY_ID;
			end
		end
	end

	always_ff @(posedge clk) begin
		token_q <= tok_next;
	end

	assign tok_out = token_q;
	assign score = score_q;

endmodule

@@ hdl/rbt_seq.sv @@
// Sequencer for the end of a tally: winner walk through the chain, then result words.
`timescale 1ns / 1ps
module rbt_seq #(
	parameter int CELLS = rbt_pkg::MAX_CANDIDATES_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      tally_go,
	input  logic [$clog2(CELLS)-1:0]  last_index,
	output rbt_pkg::seq_ctl_t         ctl,
	output logic [$clog2(CELLS)-1:0]  index
);
	import rbt_pkg::*;

	localparam int CNT_W = $clog2(CELLS);
	localparam logic [CNT_W-1:0] WALK_LAST = CNT_W'(CELLS - 1);

	state_t           state_q;
	state_t           state_d;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] cnt_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			cnt_q <= cnt_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cnt_d = cnt_q;
		ctl = '0;
		unique case (state_q)
			S_IDLE: begin
				if (tally_go) begin
					state_d = S_WALK;
					cnt_d = '0;
				end
			end
			S_WALK: begin
				// walk the winner token along the cell chain until it leaves the last one
				ctl.busy = 1'b1;
				if (cnt_q == WALK_LAST) begin
					state_d = S_EMIT;
					cnt_d = '0;
				end else begin
					cnt_d = cnt_q + CNT_W'(1);
				end
			end
			S_EMIT: begin
				ctl.busy = 1'b1;
				ctl.load = 1'b1;
				ctl.last = cnt_q == last_index;
				if (ctl.last) begin
					state_d = S_IDLE;
					ctl.clear = 1'b1;
					cnt_d = '0;
				end else begin
					cnt_d = cnt_q + CNT_W'(1);
				end
			end
			default: begin
				state_d = S_IDLE;
				cnt_d = '0;
			end
		endcase
	end

	assign index = cnt_q;

endmodule

@@ hdl/ranked_ballot_tally_unit.sv @@
// Top level of the ranked ballot tally: Borda scores and Condorcet winner.
//
//  channel  | handshake              | word
//  ---------+------------------------+-------------------------------------------
//  entry    | start, busy            | candidate_id, ballot_end, tally_end
//  config   | cfg_valid, cfg_ready   | cfg_data (candidate_count)
//  result   | result_valid (strobe)  | candidate_index, borda_score, borda_winner,
//           |                        | condorcet_winner, condorcet_found, last_result
//
// Ballot entries are taken one per cycle while busy is low; every cell updates
// its score and its pairwise row and column in the cycle of the entry.
// A word with tally_end sets busy while the winner token walks the cell chain,
// then while one result word per candidate in use goes out.
// The stores clear at the edge of the last result word; no clearing pass after reset.
// Results cannot be held off; cfg_ready is always high.
`timescale 1ns / 1ps
`include "ranked_ballot_tally_unit_macros.svh"
module ranked_ballot_tally_unit #(
	parameter int MAX_CANDIDATES = rbt_pkg::MAX_CANDIDATES_DEF,
	parameter int COUNT_WIDTH = rbt_pkg::COUNT_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [rbt_pkg::ID_W-1:0]    candidate_id,
	input  logic                        ballot_end,
	input  logic                        tally_end,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [rbt_pkg::CFG_W-1:0]   cfg_data,
	output logic                        result_valid,
	output logic [rbt_pkg::ID_W-1:0]    candidate_index,
	output logic [rbt_pkg::SCORE_W-1:0] borda_score,
	output logic [rbt_pkg::ID_W-1:0]    borda_winner,
	output logic [rbt_pkg::ID_W-1:0]    condorcet_winner,
	output logic                        condorcet_found,
	output logic                        last_result
);
	import rbt_pkg::*;

	localparam int NC = (MAX_CANDIDATES < ID_SPAN) ? MAX_CANDIDATES : ID_SPAN;
	localparam int CNT_W = $clog2(NC);
	localparam logic [CFG_W-1:0] N_LIM = CFG_W'(NC);

	logic [CFG_W-1:0]   count_q;
	logic [CFG_W-1:0]   n_act;
	logic [ID_SPAN-1:0] active;
	logic [ID_SPAN-1:0] seen_q;
	logic [ID_SPAN-1:0] new_seen;
	logic [POS_W-1:0]   pos_q;
	logic [CFG_W-1:0]   pos_ext;
	logic [POS_W-1:0]   pts;
	logic               step;
	logic               hit;
	logic               close;
	entry_t             entry;
	seq_ctl_t           ctl;
	logic [CNT_W-1:0]   index;
	logic [CNT_W-1:0]   last_index;
	token_t             tok [NC+1];
	logic [SCORE_W-1:0] scores [NC];

	logic               result_valid_q;
	logic [ID_W-1:0]    candidate_index_q;
	logic [SCORE_W-1:0] borda_score_q;
	logic [ID_W-1:0]    borda_winner_q;
	logic [ID_W-1:0]    condorcet_winner_q;
	logic               condorcet_found_q;
	logic               last_result_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= CFG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			count_q <= cfg_data;
		end
	end

	// clamp the count to at least two and at most the cells that exist
	always_comb begin
		if (count_q < CFG_MIN) begin
			n_act = CFG_MIN;
		end else if (count_q > N_LIM) begin
			n_act = N_LIM;
		end else begin
			n_act = count_q;
		end
		for (int k = 0; k < ID_SPAN; k++) begin
			active[k] = CFG_W'(k) < n_act;
		end
	end

	assign step = start && !busy;
	assign close = step && (ballot_end || tally_end);
	assign hit = step && ({1'b0, candidate_id} < n_act) && !seen_q[candidate_id];
	assign new_seen = seen_q | (hit ? (ID_SPAN'(1) << candidate_id) : '0);
	assign pos_ext = {1'b0, pos_q};
	assign pts = (pos_ext + CFG_W'(1) < n_act) ? POS_W'(n_act - CFG_W'(1) - pos_ext) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
			pos_q <= '0;
		end else if (step) begin
			if (close) begin
				seen_q <= '0;
				pos_q <= '0;
			end else begin
				seen_q <= new_seen;
				if (pos_q != POS_LAST) begin
					pos_q <= pos_q + POS_W'(1);
				end
			end
		end
	end

	always_comb begin
		entry.hit = hit;
		entry.id = candidate_id;
		entry.pts = pts;
		entry.close = close;
		entry.old_seen = seen_q;
		entry.new_seen = new_seen;
		entry.active = active;
	end

	assign tok[0] = '0;

	for (genvar k = 0; k < NC; k++) begin : g_cell
		rbt_cell #(
			.CELLS(NC),
			.COUNT_WIDTH(COUNT_WIDTH),
			.CELL_INDEX(k)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.entry(entry),
			.clear(ctl.clear),
			.tok_in(tok[k]),
			.tok_out(tok[k+1]),
			.score(scores[k])
		);
	end

	assign last_index = CNT_W'(n_act - CFG_W'(1));

	rbt_seq #(
		.CELLS(NC)
	) u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.tally_go(step && tally_end),
		.last_index(last_index),
		.ctl(ctl),
		.index(index)
	);

	assign busy = ctl.busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= ctl.load;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			candidate_index_q <= ID_W'(index);
			borda_score_q <= scores[index];
			borda_winner_q <= tok[NC].best_idx;
			condorcet_winner_q <= tok[NC].cond_idx;
			condorcet_found_q <= tok[NC].found;
			last_result_q <= ctl.last;
		end
	end

	assign result_valid = result_valid_q;
	assign candidate_index = candidate_index_q;
	assign borda_score = borda_score_q;
	assign borda_winner = borda_winner_q;
	assign condorcet_winner = condorcet_winner_q;
	assign condorcet_found = condorcet_found_q;
	assign last_result = last_result_q;

	`RBT_ASSERT_SAME(a_result_after_emit, result_valid, $past(busy), "result word outside emit")
	`RBT_ASSERT_NEXT(a_tally_sets_busy, start && !busy && tally_end, busy, "tally end left busy low")
	`RBT_ASSERT_NEXT(a_burst_continues, result_valid && !last_result, result_valid, "result burst broke off")
	`RBT_ASSERT_NEXT(a_burst_ends, result_valid && last_result, !result_valid, "result word after last")

endmodule

@@ sim/ballot_tally_checker.sv @@
// Checker for the ranked ballot tally unit: predicts every result word and compares it.
`timescale 1ns / 1ps
module ballot_tally_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic                        busy,
	input  logic [rbt_pkg::ID_W-1:0]    candidate_id,
	input  logic                        ballot_end,
	input  logic                        tally_end,
	input  logic                        cfg_valid,
	input  logic                        cfg_ready,
	input  logic [rbt_pkg::CFG_W-1:0]   cfg_data,
	input  logic                        result_valid,
	input  logic [rbt_pkg::ID_W-1:0]    candidate_index,
	input  logic [rbt_pkg::SCORE_W-1:0] borda_score,
	input  logic [rbt_pkg::ID_W-1:0]    borda_winner,
	input  logic [rbt_pkg::ID_W-1:0]    condorcet_winner,
	input  logic                        condorcet_found,
	input  logic                        last_result,
	output int                          fault_count,
	output int                          outstanding
);

	localparam int NCAND = rbt_pkg::MAX_CANDIDATES_DEF;
	localparam int PAIR_W = rbt_pkg::COUNT_WIDTH_DEF;
	localparam int SCORE_W = rbt_pkg::SCORE_W;
	localparam int POS_W = rbt_pkg::POS_W;
	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		logic [rbt_pkg::ID_W-1:0] index;
		logic [SCORE_W-1:0]       score;
		logic [rbt_pkg::ID_W-1:0] borda_win;
		logic [rbt_pkg::ID_W-1:0] condorcet_win;
		logic                     found;
		logic                     last;
	} tally_result_t;

	logic [SCORE_W-1:0]           score_tab [NCAND];
	logic [PAIR_W-1:0]            ranked_above [NCAND][NCAND];
	logic [NCAND-1:0]             named;
	logic [rbt_pkg::POS_W-1:0]    position;
	logic [rbt_pkg::CFG_W-1:0]    count_reg;
	tally_result_t                score_reports_q [$];
	tally_result_t                want_r;
	tally_result_t                got_r;
	int                           mismatches;

	function automatic int active_n(input logic [rbt_pkg::CFG_W-1:0] cnt);
		int lim;
		lim = (NCAND < 8) ? NCAND : 8;
		if (cnt < 2) return 2;
		if (cnt > lim) return lim;
		return cnt;
	endfunction

	task automatic clear_stores();
		for (int s = 0; s < NCAND; s++) begin
			score_tab[s] = '0;
			for (int o = 0; o < NCAND; o++)
				ranked_above[s][o] = '0;
		end
		named = '0;
		position = '0;
	endtask

	task automatic bump_pair(input int above, input int below);
		if (ranked_above[above][below] != {PAIR_W{1'b1}})
			ranked_above[above][below] = ranked_above[above][below] + PAIR_W'(1);
	endtask

	task automatic tally_entry(input logic [rbt_pkg::ID_W-1:0] id, input logic bend,
			input logic tend);
		int n;
		int pts;
		int bw;
		int cw;
		bit found;
		bit beats_all;
		logic [SCORE_W:0] sum;
		tally_result_t r;
		n = active_n(count_reg);
		if (id < n && !named[id]) begin
			pts = (int'(position) + 1 < n) ? n - 1 - int'(position) : 0;
			sum = {1'b0, score_tab[id]} + (SCORE_W+1)'(pts);
			score_tab[id] = sum[SCORE_W] ? {SCORE_W{1'b1}} : sum[SCORE_W-1:0];
			for (int s = 0; s < n; s++)
				if (named[s]) bump_pair(s, id);
			named[id] = 1'b1;
		end
		if (position != rbt_pkg::POS_LAST) position = position + POS_W'(1);

		// Closing a ballot ranks every named candidate above every unnamed one.
		if (bend || tend) begin
			for (int s = 0; s < n; s++) begin
				if (!named[s]) continue;
				for (int o = 0; o < n; o++)
					if (!named[o]) bump_pair(s, o);
			end
			named = '0;
			position = '0;
		end
		if (!tend) return;

		bw = 0;
		for (int c = 1; c < n; c++)
			if (score_tab[c] > score_tab[bw]) bw = c;
		cw = 0;
		found = 1'b0;
		for (int c = 0; c < n && !found; c++) begin
			beats_all = 1'b1;
			for (int o = 0; o < n; o++)
				if (o != c && !(ranked_above[c][o] > ranked_above[o][c])) beats_all = 1'b0;
			if (beats_all) begin
				cw = c;
				found = 1'b1;
			end
		end
		for (int k = 0; k < n; k++) begin
			r.index = 3'(k);
			r.score = score_tab[k];
			r.borda_win = 3'(bw);
			r.condorcet_win = 3'(cw);
			r.found = found;
			r.last = (k + 1 == n);
			score_reports_q.push_back(r);
		end
		clear_stores();
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_stores();
			count_reg = rbt_pkg::CFG_RESET;
			score_reports_q.delete();
			mismatches = 0;
			fault_count <= 0;
			outstanding <= 0;
		end else begin
			if (cfg_valid && cfg_ready) count_reg = cfg_data;
			if (start && !busy) tally_entry(candidate_id, ballot_end, tally_end);
			if (result_valid) begin
				got_r = {candidate_index, borda_score, borda_winner, condorcet_winner,
					condorcet_found, last_result};
				if (score_reports_q.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("unexpected word: idx %0d score %0d bw %0d cw %0d f %0b l %0b",
							got_r.index, got_r.score, got_r.borda_win, got_r.condorcet_win,
							got_r.found, got_r.last);
				end else begin
					want_r = score_reports_q.pop_front();
					if (got_r !== want_r) begin
						mismatches++;
						if (mismatches <= REPORT_LIMIT) begin
							$display("mismatch: expected idx %0d score %0d bw %0d cw %0d f %0b l %0b",
								want_r.index, want_r.score, want_r.borda_win,
								want_r.condorcet_win, want_r.found, want_r.last);
							$display("          actual   idx %0d score %0d bw %0d cw %0d f %0b l %0b",
								got_r.index, got_r.score, got_r.borda_win,
								got_r.condorcet_win, got_r.found, got_r.last);
						end
					end
				end
			end
			fault_count <= mismatches;
			outstanding <= score_reports_q.size();
		end
	end

endmodule

@@ sim/tb_ranked_ballot_tally_unit.sv @@
// Testbench top for the ranked ballot tally unit: drives ballots and settings, gives the verdict.
`timescale 1ns / 1ps
module tb_ranked_ballot_tally_unit;

	localparam int SETTLE_CYCLES = 24;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int RANDOM_ITEMS = 430;
	localparam int SATURATE_BALLOTS = 40;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        start = 1'b0;
	logic                        busy;
	logic [rbt_pkg::ID_W-1:0]    candidate_id = '0;
	logic                        ballot_end = 1'b0;
	logic                        tally_end = 1'b0;
	logic                        cfg_valid = 1'b0;
	logic                        cfg_ready;
	logic [rbt_pkg::CFG_W-1:0]   cfg_data = '0;
	logic                        result_valid;
	logic [rbt_pkg::ID_W-1:0]    candidate_index;
	logic [rbt_pkg::SCORE_W-1:0] borda_score;
	logic [rbt_pkg::ID_W-1:0]    borda_winner;
	logic [rbt_pkg::ID_W-1:0]    condorcet_winner;
	logic                        condorcet_found;
	logic                        last_result;
	int                          fault_count;
	int                          outstanding;
	int                          cycle_count = 0;
	int                          items_sent = 0;
	logic [rbt_pkg::CFG_W-1:0]   count_setting = rbt_pkg::CFG_RESET;

	ranked_ballot_tally_unit u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.busy             (busy),
		.candidate_id     (candidate_id),
		.ballot_end       (ballot_end),
		.tally_end        (tally_end),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_data         (cfg_data),
		.result_valid     (result_valid),
		.candidate_index  (candidate_index),
		.borda_score      (borda_score),
		.borda_winner     (borda_winner),
		.condorcet_winner (condorcet_winner),
		.condorcet_found  (condorcet_found),
		.last_result      (last_result)
	);

	ballot_tally_checker u_checker (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.busy             (busy),
		.candidate_id     (candidate_id),
		.ballot_end       (ballot_end),
		.tally_end        (tally_end),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_data         (cfg_data),
		.result_valid     (result_valid),
		.candidate_index  (candidate_index),
		.borda_score      (borda_score),
		.borda_winner     (borda_winner),
		.condorcet_winner (condorcet_winner),
		.condorcet_found  (condorcet_found),
		.last_result      (last_result),
		.fault_count      (fault_count),
		.outstanding      (outstanding)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	function automatic int ballot_length();
		if (count_setting < 2) return 2;
		if (count_setting > 8) return 8;
		return count_setting;
	endfunction

	// Hold the word until the block takes it; start stays high for a back-to-back word.
	task automatic send_entry(input logic [rbt_pkg::ID_W-1:0] id, input logic bend,
			input logic tend, input int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		candidate_id <= id;
		ballot_end <= bend;
		tally_end <= tend;
		do @(posedge clk); while (busy !== 1'b0);
		items_sent++;
	endtask

	// Wait until every predicted result word has arrived and the walk is surely over.
	task automatic drain_results();
		start <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_candidate_count(input logic [rbt_pkg::CFG_W-1:0] value);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		cfg_valid <= 1'b0;
		count_setting = value;
	endtask

	// Mostly full permutations; the rest short, overlong or random noise.
	task automatic send_ballot(input bit closes_tally, input bit burst);
		int n;
		int kind;
		int len;
		int j;
		int tmp;
		int order [8];
		logic [rbt_pkg::ID_W-1:0] id;
		logic last;
		logic bend;
		n = ballot_length();
		kind = $urandom_range(0, 9);
		for (int k = 0; k < 8; k++) order[k] = k;
		for (int k = n - 1; k > 0; k--) begin
			j = $urandom_range(0, k);
			tmp = order[k];
			order[k] = order[j];
			order[j] = tmp;
		end
		if (kind <= 5) len = n;
		else if (kind == 6) len = $urandom_range(1, n - 1);
		else if (kind == 7) len = $urandom_range(n + 1, 10);
		else len = $urandom_range(1, 10);
		for (int k = 0; k < len; k++) begin
			if (kind <= 6 || (kind == 7 && k < n)) id = 3'(order[k]);
			else id = 3'($urandom_range(0, 7));
			last = (k == len - 1);
			if (closes_tally) bend = last && ($urandom_range(0, 3) != 0);
			else bend = last && ($urandom_range(0, 15) != 0);
			send_entry(id, bend, last && closes_tally, burst ? 0 : $urandom_range(0, 15));
		end
	endtask

	initial begin
		int tallies;
		int ballots;
		bit burst;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset setting of three candidates: unused id, repeat, overlong and short
		// ballots, and a tally closed without a ballot end.
		send_entry(3'd0, 1'b0, 1'b0, 0);
		send_entry(3'd1, 1'b0, 1'b0, 0);
		send_entry(3'd2, 1'b1, 1'b0, 0);
		send_entry(3'd7, 1'b0, 1'b0, 2);
		send_entry(3'd1, 1'b0, 1'b0, 0);
		send_entry(3'd1, 1'b0, 1'b0, 0);
		send_entry(3'd0, 1'b1, 1'b0, 1);
		send_entry(3'd2, 1'b1, 1'b0, 0);
		send_entry(3'd1, 1'b0, 1'b0, 0);
		send_entry(3'd0, 1'b0, 1'b1, 0);

		// Eight candidates, with a ballot running past the last position.
		write_candidate_count(4'd8);
		for (int k = 7; k >= 0; k--) send_entry(3'(k), k == 0, 1'b0, 0);
		for (int k = 0; k < 10; k++) send_entry(3'(k % 8), 1'b0, k == 9, 0);

		write_candidate_count(4'd2);
		send_entry(3'd1, 1'b0, 1'b0, 0);
		send_entry(3'd0, 1'b1, 1'b1, 0);

		// Below the minimum; clamps to two.
		write_candidate_count(4'd0);
		send_entry(3'd0, 1'b0, 1'b1, 0);

		// Above the maximum; clamps to eight, one-name ballots back to back.
		write_candidate_count(4'd15);
		for (int k = 0; k < SATURATE_BALLOTS; k++) send_entry(3'd0, 1'b1, 1'b0, 0);
		send_entry(3'd1, 1'b1, 1'b1, 0);

		items_sent = 0;
		while (items_sent < RANDOM_ITEMS) begin
			write_candidate_count(4'($urandom_range(0, 15)));
			tallies = $urandom_range(1, 3);
			for (int t = 0; t < tallies; t++) begin
				ballots = $urandom_range(1, 5);
				burst = ($urandom_range(0, 3) == 0);
				for (int b = 0; b < ballots; b++) begin
					// Change the setting in the middle of a tally now and then.
					if (b > 0 && $urandom_range(0, 7) == 0)
						write_candidate_count(4'($urandom_range(0, 15)));
					send_ballot(b == ballots - 1, burst);
				end
			end
		end

		drain_results();
		if (fault_count == 0 && outstanding == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
